FILE: hdl/fbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_pkg: shared definitions for the frame XOR and byte parity check block
// Holds the sizing constants, command codes and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package fbpc_pkg;

    localparam int MAX_DATA_BYTES = 256;
    localparam int STORE_BYTES    = (MAX_DATA_BYTES + 7) / 8;
    localparam int CNT_W          = $clog2(MAX_DATA_BYTES + 1);
    localparam int SLOT_W         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int IDX_W          = $clog2(STORE_BYTES + 2);
    localparam int CMP_W          = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    localparam logic [1:0] CMD_DATA   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    localparam logic KIND_CHECK   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic take_rx;
        logic absorb;
        logic start_emit;
        logic emit_step;
        logic cmp_step;
        logic load_check;
        logic load_verdict;
        logic clear_frame;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic verdict_due;
        logic emit_last;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: hdl/fbpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_ctrl: sequencing controller
// Decodes accepted items and steps the datapath through validation compares
// and the check byte emission walk.
// ----------------------------------------------------------------------------
module fbpc_ctrl
    import fbpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_command,
    output logic            o_in_ready,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_V_CMP = 4'b0010,
        ST_E_RD  = 4'b0100,
        ST_E_LD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_rx = 1'b1;
                    case (i_command)
                        CMD_DATA: begin
                            o_cmd.absorb = 1'b1;
                        end
                        CMD_FINISH: begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = ST_E_RD;
                        end
                        CMD_CHECK: begin
                            n_state = ST_V_CMP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_V_CMP: begin
                if (!i_stat.verdict_due) begin
                    o_cmd.cmp_step = 1'b1;
                    n_state        = ST_IDLE;
                end else if (i_stat.out_free) begin
                    // The verdict closes the frame.
                    o_cmd.load_verdict = 1'b1;
                    o_cmd.clear_frame  = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_E_RD: begin
                n_state = ST_E_LD;
            end
            ST_E_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_check = 1'b1;
                    if (i_stat.emit_last) begin
                        o_cmd.clear_frame = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.emit_step = 1'b1;
                        n_state         = ST_E_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/fbpc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_dp: frame check datapath
// XOR accumulator, parity store with a partial byte register, compare logic
// and the result output register.
// ----------------------------------------------------------------------------
module fbpc_dp
    import fbpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_data_byte,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic            o_result_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_frame_ok,
    output logic            o_overflow
);

    // Only full parity bytes go to the store; the byte being filled lives in
    // r_cur. The fill count (data count / 8) says which entries are valid,
    // so the store needs no clearing.
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    logic [7:0]       r_xor;
    logic [7:0]       r_cur;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_ci;
    logic             r_miss;
    logic             r_ovf;
    logic [7:0]       r_rx;

    logic       r_ov;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_ok;
    logic       r_ovf_out;

    logic              bit_par;
    logic [2:0]        bit_pos;
    logic              room;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [SLOT_W-1:0] mem_ra;
    logic [CMP_W-1:0]  full_slots;
    logic [CMP_W-1:0]  ci_ext;
    logic [CMP_W-1:0]  ci_inc;
    logic [CMP_W-1:0]  total;
    logic [7:0]        expected;
    logic              miss_now;
    logic              out_free;

    assign bit_par = ^i_data_byte;
    assign bit_pos = 3'd7 - r_count[2:0];
    assign room    = (r_count < CNT_W'(MAX_DATA_BYTES));
    assign mem_we  = i_cmd.absorb && room && (r_count[2:0] == 3'd7);
    assign mem_wa  = r_count[3 +: SLOT_W];
    assign mem_wd  = r_cur | {7'd0, bit_par};
    assign mem_ra  = (r_ci == '0) ? '0 : SLOT_W'(r_ci - IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    assign full_slots = CMP_W'(r_count >> 3);
    assign ci_ext     = CMP_W'(r_ci);
    assign ci_inc     = ci_ext + CMP_W'(1);
    assign total      = CMP_W'(1) + ((CMP_W'(r_count) + CMP_W'(7)) >> 3);

    // Position zero is the XOR byte; a position past the full bytes is the
    // partial byte still being filled.
    always_comb begin
        if (r_ci == '0) begin
            expected = r_xor;
        end else if ((ci_ext - CMP_W'(1)) < full_slots) begin
            expected = r_rdata;
        end else begin
            expected = r_cur;
        end
    end

    assign miss_now = (r_rx != expected);
    assign out_free = !r_ov || i_out_ready;

    assign o_stat.out_free    = out_free;
    assign o_stat.verdict_due = (ci_inc >= total);
    assign o_stat.emit_last   = (ci_inc == total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor   <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_ci    <= '0;
            r_miss  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear_frame) begin
            r_xor   <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_ci    <= '0;
            r_miss  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.absorb) begin
                if (room) begin
                    r_xor   <= r_xor ^ i_data_byte;
                    r_count <= r_count + CNT_W'(1);
                    if (r_count[2:0] == 3'd7) begin
                        r_cur <= '0;
                    end else begin
                        r_cur[bit_pos] <= r_cur[bit_pos] | bit_par;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start_emit) begin
                r_ci <= '0;
            end
            if (i_cmd.emit_step) begin
                r_ci <= r_ci + IDX_W'(1);
            end
            if (i_cmd.cmp_step) begin
                r_ci   <= r_ci + IDX_W'(1);
                r_miss <= r_miss | miss_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_rx) begin
            r_rx <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_check || i_cmd.load_verdict) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_check) begin
            r_kind    <= KIND_CHECK;
            r_byte    <= expected;
            r_last    <= (ci_inc == total);
            r_ok      <= 1'b0;
            r_ovf_out <= r_ovf;
        end else if (i_cmd.load_verdict) begin
            r_kind    <= KIND_VERDICT;
            r_byte    <= '0;
            r_last    <= 1'b0;
            r_ok      <= !(r_miss | miss_now);
            r_ovf_out <= r_ovf;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_kind;
    assign o_out_byte    = r_byte;
    assign o_last        = r_last;
    assign o_frame_ok    = r_ok;
    assign o_overflow    = r_ovf_out;

endmodule
`default_nettype wire

FILE: hdl/frame_xor_and_byte_parity_check_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Data bytes are absorbed one per cycle while the controller is idle and ready.
// A received check byte is registered and compared in the compare state; a verdict
// is loaded into the output register from that state, or later while the output
// register still holds an earlier item. After a finish, each check byte goes through
// a read state for the registered parity store read and then a load state.
// Reset is synchronous and active low; it clears the frame state and output valid.
// ----------------------------------------------------------------------------
// frame_xor_and_byte_parity_check_top: frame XOR and byte parity check
// Generates or validates a longitudinal XOR byte and packed byte parity bits.
// ----------------------------------------------------------------------------
module frame_xor_and_byte_parity_check_top
    import fbpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_result_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_frame_ok,
    output logic            o_overflow
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fbpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fbpc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_frame_ok    (o_frame_ok),
        .o_overflow    (o_overflow)
    );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the frame XOR and byte parity check block
// Drives data, finish, received check and ignored items through the input
// channel and predicts the XOR byte, the packed parity bytes and the verdicts.
// Every result is compared field by field with the oldest prediction.
// Idle gaps are applied on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top
    import fbpc_pkg::*;
();

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int         ALL_CHECKS  = STORE_BYTES + 1;

    typedef struct {
        logic       kind;
        logic [7:0] value;
        logic       last;
        logic       ok;
        logic       ovf;
    } t_frame_result;

    // Tracks the frame the block is working on and keeps the results still owed.
    class t_frame_check_tracker;
        logic [7:0]    lrc;
        logic [7:0]    parity_bytes [STORE_BYTES];
        int            n_data;
        int            compared;
        bit            mismatch;
        bit            dropped;
        t_frame_result pending_results [$];
        int            fail_count;

        function new();
            clear_frame();
            fail_count = 0;
        endfunction

        function void clear_frame();
            lrc = 8'h00;
            foreach (parity_bytes[i]) parity_bytes[i] = 8'h00;
            n_data   = 0;
            compared = 0;
            mismatch = 1'b0;
            dropped  = 1'b0;
        endfunction

        function int check_count();
            return 1 + (n_data + 7) / 8;
        endfunction

        // Position zero is the XOR byte, the rest are the packed parity bytes.
        function logic [7:0] check_byte(int idx);
            if (idx == 0) return lrc;
            if (idx - 1 < STORE_BYTES) return parity_bytes[idx - 1];
            return 8'h00;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void owe(logic kind, logic [7:0] value, logic last, logic ok);
            t_frame_result r;
            r.kind  = kind;
            r.value = value;
            r.last  = last;
            r.ok    = ok;
            r.ovf   = dropped;
            pending_results.push_back(r);
        endfunction

        function void absorb_item(logic [1:0] cmd, logic [7:0] value);
            int total;
            total = check_count();
            case (cmd)
                CMD_DATA: begin
                    if (n_data < MAX_DATA_BYTES) begin
                        lrc ^= value;
                        parity_bytes[n_data / 8][7 - (n_data % 8)] = ^value;
                        n_data++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    for (int i = 0; i < total && i < ALL_CHECKS; i++) begin
                        owe(KIND_CHECK, check_byte(i), (i + 1 == total), 1'b0);
                    end
                    clear_frame();
                end
                CMD_CHECK: begin
                    if (compared < total) begin
                        if (value != check_byte(compared)) mismatch = 1'b1;
                        compared++;
                    end
                    if (compared >= total) begin
                        owe(KIND_VERDICT, 8'h00, 1'b0, !mismatch);
                        clear_frame();
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void match_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing awaited: kind %0d byte %0h",
                       got.kind, got.value);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("out_byte", want.value, got.value);
            compare_field("last", want.last, got.last);
            compare_field("frame_ok", want.ok, got.ok);
            compare_field("overflow", want.ovf, got.ovf);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_command   = CMD_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_result_kind;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       o_frame_ok;
    logic       o_overflow;

    t_frame_check_tracker tracker = new();

    int         items_sent = 0;
    int         burst_left = 0;
    int         rx_cycle   = 0;
    int         rx_stall   = 0;
    int         frame_no;
    int         frame_len;
    int         ending;
    logic [7:0] corner_bytes [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                     8'h55, 8'hAA, 8'h03};

    frame_xor_and_byte_parity_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_frame_ok    (o_frame_ok),
        .o_overflow    (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    // The receiver cycles through phases: always ready, short stalls, long stalls.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_stall > 0) begin
            rx_stall--;
        end else begin
            case ((rx_cycle / 300) % 3)
                1: if ($urandom_range(0, 2) == 0) rx_stall = $urandom_range(1, 3);
                2: if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(4, 10);
                default: ;
            endcase
        end
        i_out_ready <= (rx_stall == 0);
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind  = o_result_kind;
            got.value = o_out_byte;
            got.last  = o_last;
            got.ok    = o_frame_ok;
            got.ovf   = o_overflow;
            tracker.match_result(got);
        end
    end

    // Presents one item, waits for its acceptance and then applies burst idling.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] value);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= value;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.absorb_item(cmd, value);
        if (cmd != CMD_IGNORED) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_frame_data(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(CMD_IGNORED, 8'($urandom_range(0, 255)));
            send_item(CMD_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    // Sends up to count of the check bytes still awaited; one bit is flipped
    // in the check byte sent at index flip_at of this call, if it is reached.
    task automatic send_checks(input int count, input int flip_at);
        int         remaining;
        logic [7:0] value;
        remaining = tracker.check_count() - tracker.compared;
        if (count > remaining) count = remaining;
        for (int i = 0; i < count; i++) begin
            value = tracker.check_byte(tracker.compared);
            if (i == flip_at) value ^= 8'h01 << $urandom_range(0, 7);
            send_item(CMD_CHECK, value);
        end
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored command, empty frames, corner bytes with padding,
        // good and bad validation, finish and data in the middle of validation.
        send_item(CMD_IGNORED, 8'hFF);
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_CHECK, 8'h00);
        send_item(CMD_CHECK, 8'h80);
        foreach (corner_bytes[i]) send_item(CMD_DATA, corner_bytes[i]);
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_DATA, 8'h12);
        send_item(CMD_DATA, 8'h34);
        send_checks(ALL_CHECKS, -1);
        send_item(CMD_DATA, 8'h0F);
        send_checks(ALL_CHECKS, 1);
        send_item(CMD_DATA, 8'hC3);
        send_checks(1, -1);
        send_item(CMD_FINISH, 8'h5A);
        send_item(CMD_DATA, 8'h07);
        send_checks(1, -1);
        send_item(CMD_DATA, 8'h08);
        send_checks(ALL_CHECKS, -1);
        wait_results_done();

        // Random frames; one of them runs past capacity and is finished, which
        // gives the longest run of check bytes.
        items_sent = 0;
        frame_no   = 0;
        while (items_sent < 150) begin
            if (frame_no == 2) begin
                frame_len = MAX_DATA_BYTES + $urandom_range(1, 4);
            end else begin
                frame_len = $urandom_range(0, 24);
            end
            send_frame_data(frame_len);
            if (frame_no == 2) ending = 0;
            else ending = $urandom_range(0, 9);
            case (ending)
                0, 1, 2, 3: send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
                4, 5, 6: send_checks(ALL_CHECKS, -1);
                7: send_checks(ALL_CHECKS, $urandom_range(0, 4));
                8: begin
                    send_checks($urandom_range(1, 3), -1);
                    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
                end
                default: begin
                    send_checks($urandom_range(1, 2), -1);
                    send_frame_data($urandom_range(1, 10));
                    send_checks(ALL_CHECKS, $urandom_range(0, 1) == 0 ? -1 : 0);
                end
            endcase
            if (frame_no == 4 || $urandom_range(0, 7) == 0) wait_results_done();
            frame_no++;
        end

        wait_results_done();
        repeat (16) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: frame_xor_and_byte_parity_check_top.f
hdl/fbpc_pkg.sv
hdl/fbpc_ctrl.sv
hdl/fbpc_dp.sv
hdl/frame_xor_and_byte_parity_check_top.sv
test/tb_top.sv
